FILE: rtl/core/assert_macros.svh
// Assertion macros used by the triangle strip decoder parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, skipped while reset is held.
`define TSID_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a consequence in the next one.
`define TSID_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: rtl/core/tsid_pkg.sv
// Shared types and constants of the triangle strip index decoder.
package tsid_pkg;

    localparam int unsigned IDX_W = 16;
    localparam int unsigned CNT_W = 8;

    // Input command codes carried on the slave-side tuser.
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // End reason codes, meaningful only with surface_done.
    localparam logic END_TARGET = 1'b0;
    localparam logic END_EMPTY  = 1'b1;

    typedef struct packed {
        logic             tri_valid;
        logic [IDX_W-1:0] vert_first;
        logic [IDX_W-1:0] vert_second;
        logic [IDX_W-1:0] vert_third;
        logic             surface_done;
        logic             end_reason;
        logic [IDX_W-1:0] triangles_written;
    } t_result;

endpackage

FILE: rtl/core/tsid_parser.sv
// Input register, strip parsing state and triangle assembly logic.
`include "assert_macros.svh"

module tsid_parser
    import tsid_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cmd,
    input  logic [IDX_W-1:0] i_value,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_LOW,
        PH_HIGH
    } t_phase;

    // Input register.
    logic             r_in_valid;
    logic             r_cmd;
    logic [IDX_W-1:0] r_value;

    // Parsing state.
    logic             r_active,    n_active;
    t_phase           r_phase,     n_phase;
    logic [7:0]       r_low,       n_low;
    logic [CNT_W-1:0] r_len,       n_len;
    logic [CNT_W-1:0] r_pos,       n_pos;
    logic [IDX_W-1:0] r_prev,      n_prev;
    logic [IDX_W-1:0] r_prev2,     n_prev2;
    logic [CNT_W-1:0] r_strip_tri, n_strip_tri;
    logic [IDX_W-1:0] r_total,     n_total;
    logic [IDX_W-1:0] r_target,    n_target;

    logic             n_emit;
    t_result          n_res;
    logic             consume;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] vb;
    logic [IDX_W-1:0] vc;
    logic [CNT_W:0]   pos_inc;
    logic [CNT_W-1:0] len_eff;
    logic             strip_end;
    logic             tri_ok;

    assign idx     = {r_value[7:0], r_low};
    assign vb      = r_pos[0] ? r_prev2 : r_prev;
    assign vc      = r_pos[0] ? r_prev  : r_prev2;
    assign pos_inc = {1'b0, r_pos} + {{CNT_W{1'b0}}, 1'b1};
    assign len_eff = (r_len < CNT_W'(3)) ? CNT_W'(3) : r_len;
    assign strip_end = pos_inc >= {1'b0, len_eff};
    assign tri_ok  = (r_pos >= CNT_W'(2)) && (idx != vb) && (idx != vc) && (vb != vc)
                     && (r_total < r_target);

    always_comb begin
        n_active    = r_active;
        n_phase     = r_phase;
        n_low       = r_low;
        n_len       = r_len;
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_prev2     = r_prev2;
        n_strip_tri = r_strip_tri;
        n_total     = r_total;
        n_target    = r_target;
        n_emit      = 1'b0;
        n_res       = '0;

        if (r_cmd == CMD_BEGIN) begin
            n_phase     = PH_COUNT;
            n_low       = '0;
            n_len       = '0;
            n_pos       = '0;
            n_prev      = '0;
            n_prev2     = '0;
            n_strip_tri = '0;
            n_total     = '0;
            n_target    = r_value;
            n_active    = (r_value != '0);
            if (r_value == '0) begin
                n_emit             = 1'b1;
                n_res.surface_done = 1'b1;
                n_res.end_reason   = END_TARGET;
            end
        end else if (r_active) begin
            unique case (r_phase)
                PH_COUNT: begin
                    n_len       = r_value[CNT_W-1:0];
                    n_pos       = '0;
                    n_strip_tri = '0;
                    n_phase     = PH_LOW;
                end
                PH_LOW: begin
                    n_low   = r_value[7:0];
                    n_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    if (tri_ok) begin
                        n_total = r_total + IDX_W'(1);
                        if (r_strip_tri != '1) begin
                            n_strip_tri = r_strip_tri + CNT_W'(1);
                        end
                        n_res.tri_valid   = 1'b1;
                        n_res.vert_first  = idx;
                        n_res.vert_second = vb;
                        n_res.vert_third  = vc;
                    end
                    n_prev2 = r_prev;
                    n_prev  = idx;
                    n_pos   = pos_inc[CNT_W] ? '1 : pos_inc[CNT_W-1:0];
                    if (strip_end) begin
                        // Target reached takes priority over an empty strip.
                        if (n_total >= r_target) begin
                            n_res.surface_done = 1'b1;
                            n_res.end_reason   = END_TARGET;
                        end else if (n_strip_tri == '0) begin
                            n_res.surface_done = 1'b1;
                            n_res.end_reason   = END_EMPTY;
                        end
                        n_phase     = PH_COUNT;
                        n_pos       = '0;
                        n_strip_tri = '0;
                        if (n_res.surface_done) begin
                            n_active = 1'b0;
                        end
                    end else begin
                        n_phase = PH_LOW;
                    end
                    n_emit = tri_ok || n_res.surface_done;
                end
                default: begin
                    n_phase = PH_COUNT;
                end
            endcase
        end
        n_res.triangles_written = n_total;
    end

    assign consume     = r_in_valid && (!n_emit || i_res_ready);
    assign o_in_ready  = !r_in_valid || consume;
    assign o_res_valid = r_in_valid && n_emit;
    assign o_res       = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_active    <= 1'b0;
            r_phase     <= PH_COUNT;
            r_low       <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_prev      <= '0;
            r_prev2     <= '0;
            r_strip_tri <= '0;
            r_total     <= '0;
            r_target    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (consume) begin
                r_active    <= n_active;
                r_phase     <= n_phase;
                r_low       <= n_low;
                r_len       <= n_len;
                r_pos       <= n_pos;
                r_prev      <= n_prev;
                r_prev2     <= n_prev2;
                r_strip_tri <= n_strip_tri;
                r_total     <= n_total;
                r_target    <= n_target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
    end

    `TSID_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n,
        consume && n_emit && n_res.surface_done, !r_active,
        "surface stayed active after its final result")
    `TSID_ASSERT(a_tri_distinct, i_clk, i_rst_n,
        !(o_res_valid && o_res.tri_valid) ||
        (o_res.vert_first != o_res.vert_second && o_res.vert_first != o_res.vert_third &&
         o_res.vert_second != o_res.vert_third),
        "emitted triangle has a repeated vertex")
    `TSID_ASSERT(a_total_in_target, i_clk, i_rst_n,
        !r_active || (r_total <= r_target),
        "triangle count passed the surface target")

endmodule

FILE: rtl/core/tsid_out_buf.sv
// Result register between the parser and the master-side stream.
module tsid_out_buf
    import tsid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: rtl/core/triangle_strip_index_decoder_top.sv
// Top level of the triangle strip index decoder.
//
// This block turns a byte stream of triangle strips into a stream of single
// triangles. A transfer with tuser = 0 begins a surface and carries its
// triangle target in tdata; a transfer with tuser = 1 carries one stream byte
// in tdata[7:0]. Each strip record is a count byte followed by 16-bit
// little-endian vertex indices (at least three are read, even for a count
// below three). From the third index on, each index forms a triangle with the
// two before it, with winding that alternates by position; triangles with a
// repeated vertex, or past the target, are dropped while the strip is still
// consumed. When a strip ends and the target is reached or the strip gave no
// triangle, the final result carries tlast and the surface closes; bytes
// arriving while no surface is open are discarded. A zero target yields one
// final result at once. Each transfer makes zero or one result. The block
// takes one input transfer per clock cycle while the output is not stalled:
// every item passes through an input register, compare and update logic,
// and a result register. Input is still accepted while a finished result
// waits for tready, until both the input register and the result register
// are full.
module triangle_strip_index_decoder_top
    import tsid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] value
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] vert_first, [31:16] vert_second,
                                        // [47:32] vert_third, [63:48] triangles_written
    output logic [1:0]  m_axis_tuser,   // [0] tri_valid, [1] end_reason
    output logic        m_axis_tlast    // surface_done
);

    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    tsid_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    tsid_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    // Pack the result fields onto the stream ports, lowest field first.
    assign m_axis_tdata = {out_res.triangles_written, out_res.vert_third,
                           out_res.vert_second, out_res.vert_first};
    assign m_axis_tuser = {out_res.end_reason, out_res.tri_valid};
    assign m_axis_tlast = out_res.surface_done;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the triangle strip index decoder top level.
module tb;
    import tsid_pkg::*;

    // Parse position inside a strip record.
    typedef enum logic [1:0] {RD_COUNT, RD_LOW, RD_HIGH} t_read_phase;

    localparam int IDLE_PCT   = 30;
    localparam int HOLD_CYCLES = 150;
    localparam int RANDOM_ITEMS = 1530;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] value
    logic        s_axis_tuser = 1'b0;  // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // vert_first, vert_second, vert_third, triangles_written
    logic [1:0]  m_axis_tuser;         // [0] tri_valid, [1] end_reason
    logic        m_axis_tlast;         // surface_done

    triangle_strip_index_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the decoder state, advanced once per accepted input transfer.
    bit          surf_open = 1'b0;
    t_read_phase rd_phase = RD_COUNT;
    logic [7:0]  low_hold = '0;
    logic [7:0]  strip_len = '0;
    logic [7:0]  strip_pos = '0;
    logic [7:0]  strip_tris = '0;
    logic [15:0] prev_idx = '0;
    logic [15:0] prev2_idx = '0;
    logic [15:0] tri_total = '0;
    logic [15:0] tri_target = '0;

    t_result decoded_tris[$];
    t_result seen_tri;
    t_result owed_tri;
    int      result_errors = 0;
    int      sent_items = 0;
    bit      src_idle_en = 1'b1;
    bit      sink_idle_en = 1'b1;
    bit      hold_request = 1'b0;

    // Works out the result, if any, that one accepted transfer causes.
    task automatic decode_transfer(input logic cmd, input logic [15:0] val);
        t_result     r;
        logic [15:0] idx;
        logic [15:0] va;
        logic [15:0] vb;
        logic [15:0] vc;
        logic        emit;
        logic        done;
        logic        why;
        int          pos;
        int          len;
        sent_items++;
        r = '0;
        emit = 1'b0;
        done = 1'b0;
        why = END_TARGET;
        va = '0;
        vb = '0;
        vc = '0;
        if (cmd == CMD_BEGIN) begin
            rd_phase = RD_COUNT;
            low_hold = '0;
            strip_len = '0;
            strip_pos = '0;
            strip_tris = '0;
            prev_idx = '0;
            prev2_idx = '0;
            tri_total = '0;
            tri_target = val;
            surf_open = (val != 16'd0);
            // A zero target closes the surface at once.
            if (val == 16'd0) begin
                r.surface_done = 1'b1;
                r.end_reason = END_TARGET;
                decoded_tris.push_back(r);
            end
            return;
        end
        if (!surf_open)
            return;
        case (rd_phase)
            RD_COUNT: begin
                strip_len = val[7:0];
                strip_pos = '0;
                strip_tris = '0;
                rd_phase = RD_LOW;
            end
            RD_LOW: begin
                low_hold = val[7:0];
                rd_phase = RD_HIGH;
            end
            default: begin
                idx = {val[7:0], low_hold};
                pos = int'(strip_pos);
                if (pos >= 2) begin
                    va = idx;
                    // Winding alternates with the position in the strip.
                    if (pos % 2 == 0) begin
                        vb = prev_idx;
                        vc = prev2_idx;
                    end else begin
                        vb = prev2_idx;
                        vc = prev_idx;
                    end
                    if (va != vb && va != vc && vb != vc && tri_total < tri_target) begin
                        emit = 1'b1;
                        tri_total++;
                        if (strip_tris != 8'hFF)
                            strip_tris++;
                    end
                end
                prev2_idx = prev_idx;
                prev_idx = idx;
                pos++;
                strip_pos = (pos > 255) ? 8'hFF : 8'(pos);
                len = (strip_len < 8'd3) ? 3 : int'(strip_len);
                if (pos >= len) begin
                    if (tri_total >= tri_target) begin
                        done = 1'b1;
                        why = END_TARGET;
                    end else if (strip_tris == 8'd0) begin
                        done = 1'b1;
                        why = END_EMPTY;
                    end
                    rd_phase = RD_COUNT;
                    strip_pos = '0;
                    strip_tris = '0;
                    if (done)
                        surf_open = 1'b0;
                end else begin
                    rd_phase = RD_LOW;
                end
                if (emit || done) begin
                    r.tri_valid = emit;
                    r.vert_first = emit ? va : '0;
                    r.vert_second = emit ? vb : '0;
                    r.vert_third = emit ? vc : '0;
                    r.surface_done = done;
                    r.end_reason = done ? why : END_TARGET;
                    r.triangles_written = tri_total;
                    decoded_tris.push_back(r);
                end
            end
        endcase
    endtask

    // Offers one transfer, with an occasional gap in front, and waits for acceptance.
    task automatic send_item(input logic cmd, input logic [15:0] val);
        if (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 16'($urandom);
            s_axis_tuser <= 1'($urandom);
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= val;
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        decode_transfer(cmd, val);
    endtask

    // The upper byte of a stream byte transfer is ignored, so it carries noise.
    task automatic send_byte(input logic [7:0] b);
        logic [7:0] junk;
        junk = 8'($urandom);
        send_item(CMD_BYTE, {junk, b});
    endtask

    task automatic send_index(input logic [15:0] idx);
        send_byte(idx[7:0]);
        send_byte(idx[15:8]);
    endtask

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            result_errors++;
            $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    // Result checker: every output transfer is matched against the oldest decoded entry.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_tri.tri_valid = m_axis_tuser[0];
            seen_tri.end_reason = m_axis_tuser[1];
            seen_tri.surface_done = m_axis_tlast;
            seen_tri.vert_first = m_axis_tdata[15:0];
            seen_tri.vert_second = m_axis_tdata[31:16];
            seen_tri.vert_third = m_axis_tdata[47:32];
            seen_tri.triangles_written = m_axis_tdata[63:48];
            if (decoded_tris.size() == 0) begin
                result_errors++;
                $display("%0t: expected no transfer, actual tdata %h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                owed_tri = decoded_tris.pop_front();
                compare_field("tri_valid", 16'(owed_tri.tri_valid),
                              16'(seen_tri.tri_valid));
                compare_field("vert_first", owed_tri.vert_first, seen_tri.vert_first);
                compare_field("vert_second", owed_tri.vert_second, seen_tri.vert_second);
                compare_field("vert_third", owed_tri.vert_third, seen_tri.vert_third);
                compare_field("surface_done", 16'(owed_tri.surface_done),
                              16'(seen_tri.surface_done));
                compare_field("end_reason", 16'(owed_tri.end_reason),
                              16'(seen_tri.end_reason));
                compare_field("triangles_written", owed_tri.triangles_written,
                              seen_tri.triangles_written);
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (sink_idle_en) begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Zero target closes at once; a byte sent afterwards finds the block idle.
    task automatic test_zero_target();
        send_item(CMD_BEGIN, 16'd0);
        send_item(CMD_BYTE, 16'hFFFF);
    endtask

    // Short counts still read three indices; a strip of repeats ends the surface empty.
    task automatic test_short_strips();
        send_item(CMD_BEGIN, 16'hFFFF);
        send_byte(8'd0);
        send_index(16'hFFFF);
        send_index(16'h0000);
        send_index(16'h1234);
        send_byte(8'd2);
        send_index(16'h0007);
        send_index(16'h0007);
        send_index(16'h0007);
        send_byte(8'hFF);
    endtask

    // A begin in mid-record drops the surface; the new target stops output early.
    task automatic test_restart();
        send_item(CMD_BEGIN, 16'd5);
        send_byte(8'd2);
        send_byte(8'h11);
        send_item(CMD_BEGIN, 16'd1);
        send_byte(8'd4);
        send_index(16'd1);
        send_index(16'd2);
        send_index(16'd3);
        send_index(16'd4);
    endtask

    // Output held off while a long strip streams in, so the block stalls its input.
    task automatic test_output_hold();
        int i;
        src_idle_en = 1'b0;
        hold_request = 1'b1;
        send_item(CMD_BEGIN, 16'hFFFF);
        send_byte(8'd40);
        for (i = 0; i < 40; i++)
            send_index(16'(16'hA500 + i));
        send_byte(8'd3);
        for (i = 0; i < 3; i++)
            send_index(16'h5AA5);
        src_idle_en = 1'b1;
    endtask

    // One strip record with random content; may break off to leave a partial record.
    task automatic random_strip(output bit aborted);
        int          cnt;
        int          n;
        int          mode;
        int          i;
        int          off;
        logic [15:0] base;
        logic [15:0] idx;
        aborted = 1'b0;
        off = $urandom_range(99);
        if (off < 2)
            cnt = 255;
        else if (off < 12)
            cnt = $urandom_range(9, 40);
        else
            cnt = $urandom_range(0, 8);
        n = (cnt < 3) ? 3 : cnt;
        mode = $urandom_range(9);
        base = 16'($urandom);
        send_byte(8'(cnt));
        for (i = 0; i < n; i++) begin
            if ($urandom_range(299) == 0) begin
                if ($urandom_range(1) == 1)
                    send_byte(8'($urandom));
                aborted = 1'b1;
                return;
            end
            case (mode)
                0: idx = base;
                1, 2: idx = 16'($urandom);
                default: begin
                    off = $urandom_range(0, 5);
                    idx = base + 16'(off);
                end
            endcase
            send_index(idx);
        end
    endtask

    task automatic random_surface();
        int          pick;
        int          strips;
        bit          aborted;
        logic [15:0] target;
        pick = $urandom_range(99);
        if (pick < 10)
            target = 16'd0;
        else if (pick < 60)
            target = 16'($urandom_range(1, 12));
        else if (pick < 80)
            target = 16'($urandom_range(13, 60));
        else if (pick < 90)
            target = 16'hFFFF;
        else
            target = 16'($urandom);
        send_item(CMD_BEGIN, target);
        strips = 0;
        aborted = 1'b0;
        while (surf_open && !aborted && strips < 40) begin
            random_strip(aborted);
            strips++;
        end
        // Stray bytes after a closed surface must be swallowed.
        if (!surf_open && $urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    endtask

    // Random surfaces, with a stretch in the middle where neither side idles.
    task automatic test_random_surfaces();
        int goal;
        goal = sent_items + RANDOM_ITEMS;
        while (sent_items < goal - 1150)
            random_surface();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        while (sent_items < goal - 850)
            random_surface();
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        while (sent_items < goal)
            random_surface();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_target();
        test_short_strips();
        test_restart();
        test_output_hold();
        test_random_surfaces();
        s_axis_tvalid <= 1'b0;
        while (decoded_tris.size() != 0)
            @(posedge i_clk);
        // Catch any stray result that trails the last expected one.
        repeat (10) @(posedge i_clk);
        if (result_errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
